FILE: rtl/core/fat_cluster_usage_counter_defines.svh
// Assertion macros shared by the counter's modules.
// Each expects clk and rst_n in scope.
`ifndef FAT_CLUSTER_USAGE_COUNTER_DEFINES_SVH
`define FAT_CLUSTER_USAGE_COUNTER_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define FCUC_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fcuc check failed");

// Consequent holds in the same cycle as the antecedent.
`define FCUC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcuc check failed");

// Consequent holds in the cycle after the antecedent.
`define FCUC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcuc check failed");

`endif

FILE: rtl/core/fcuc_pkg.sv
package fcuc_pkg;

    localparam int ENTRY_W     = 28;
    localparam int INDEX_W     = 29;
    localparam int REG_INDEX_W = 2;

    // fat_width codes; the unused code behaves as thirty-two-bit
    localparam logic [1:0] WIDTH_FAT12 = 2'd0;
    localparam logic [1:0] WIDTH_FAT16 = 2'd1;
    localparam logic [1:0] WIDTH_FAT32 = 2'd2;

    localparam logic [REG_INDEX_W-1:0] REG_FAT_WIDTH     = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_CLUSTER_COUNT = 2'd1;

    localparam logic [ENTRY_W-1:0] BAD12 = 28'h0000FF7;
    localparam logic [ENTRY_W-1:0] BAD16 = 28'h000FFF7;
    localparam logic [ENTRY_W-1:0] BAD32 = 28'hFFFFFF7;

    localparam logic [INDEX_W-1:0] INDEX_MAX     = 29'h1FFFFFFF;
    localparam logic [INDEX_W-1:0] FIRST_CLUSTER = 29'd2;

    typedef struct packed {
        logic [1:0]         fat_width;
        logic [ENTRY_W-1:0] cluster_count;
        logic [INDEX_W-1:0] limit;          // cluster_count + 2
    } fcuc_cfg_t;

    typedef struct packed {
        logic [1:0] n_used;
        logic [1:0] n_bad;
        logic       last;
    } fcuc_rec_t;

    function automatic logic [INDEX_W-1:0] index_inc(input logic [INDEX_W-1:0] idx);
        return (idx == INDEX_MAX) ? idx : idx + 1'b1;
    endfunction

endpackage

FILE: rtl/core/fcuc_channels.sv
interface fcuc_byte_if import fcuc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface fcuc_count_if import fcuc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] used_count;
    logic [ENTRY_W-1:0] bad_count;
    logic [ENTRY_W-1:0] free_count;

    modport source (output valid, output used_count, output bad_count, output free_count,
                    input ready);
    modport sink   (input valid, input used_count, input bad_count, input free_count,
                    output ready);
endinterface

interface fcuc_cfg_if import fcuc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [REG_INDEX_W-1:0] index;
    logic [ENTRY_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/fat_cluster_usage_counter.sv
// Result: the front assembles and classifies each byte in its accept cycle; the
// result is registered as the back pops the last record, after any ahead of it.
// Throughput: one table byte per cycle while the queue has room; the back updates
// counters one entry per cycle unless a last record waits on a held result.
// Reset: asynchronous, active low; fat_width returns to 1, cluster_count to 0,
// and the assembly state, counters and result valid flag clear at once.
module fat_cluster_usage_counter import fcuc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    fcuc_byte_if.sink    bytes,
    fcuc_count_if.source counts,
    fcuc_cfg_if.sink     cfg
);

    fcuc_cfg_t          cfg_reg;
    logic               fr_valid, fr_ready;
    fcuc_rec_t          fr_rec;
    logic               bk_valid, bk_ready;
    fcuc_rec_t          bk_rec;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fat_width     <= WIDTH_FAT16;
            cfg_reg.cluster_count <= '0;
            cfg_reg.limit         <= FIRST_CLUSTER;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FAT_WIDTH:
                begin
                    cfg_reg.fat_width <= cfg.data[1:0];
                end
                REG_CLUSTER_COUNT:
                begin
                    cfg_reg.cluster_count <= cfg.data;
                    cfg_reg.limit         <= INDEX_W'(cfg.data) + FIRST_CLUSTER;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    fcuc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .cfg       (cfg_reg),
        .rec_valid (fr_valid),
        .rec       (fr_rec),
        .rec_ready (fr_ready)
    );

    fcuc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_rec   (fr_rec),
        .rd_valid (bk_valid),
        .rd_rec   (bk_rec),
        .rd_ready (bk_ready)
    );

    fcuc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (bk_valid),
        .rec           (bk_rec),
        .rec_ready     (bk_ready),
        .cluster_count (cfg_reg.cluster_count),
        .counts        (counts)
    );

endmodule

FILE: rtl/core/fcuc_front.sv
module fcuc_front import fcuc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    fcuc_byte_if.sink  bytes,
    input  fcuc_cfg_t  cfg,
    output logic       rec_valid,
    output fcuc_rec_t  rec,
    input  logic       rec_ready
);

    logic [23:0]        gather_reg, gather_next;
    logic [1:0]         phase_reg, phase_next;
    logic [INDEX_W-1:0] index_reg, index_next;

    logic               take;
    logic [1:0]         need_m1;
    logic               complete;
    logic               odd_tail;
    logic               fat12;
    logic [ENTRY_W-1:0] e0, e1, mark, v0;
    logic               act0, act1;
    logic [INDEX_W-1:0] idx1, idx2;
    logic               win0, win1;
    logic               bad0, bad1, used0, used1;

    assign bytes.ready = rec_ready;
    assign rec_valid   = bytes.valid;
    assign take        = bytes.valid && rec_ready;
    assign fat12       = (cfg.fat_width == WIDTH_FAT12);

    always_comb
    begin
        unique case (cfg.fat_width)
            WIDTH_FAT12:
            begin
                need_m1 = 2'd2;
                e0      = {16'b0, gather_reg[11:0]};
                e1      = {16'b0, bytes.data_byte, gather_reg[15:12]};
                mark    = BAD12;
            end
            WIDTH_FAT16:
            begin
                need_m1 = 2'd1;
                e0      = {12'b0, bytes.data_byte, gather_reg[7:0]};
                e1      = '0;
                mark    = BAD16;
            end
            default:
            begin
                need_m1 = 2'd3;
                e0      = {bytes.data_byte[3:0], gather_reg};
                e1      = '0;
                mark    = BAD32;
            end
        endcase
    end

    assign complete = (phase_reg >= need_m1);
    // two bytes of a FAT12 group left at the end still form one entry
    assign odd_tail = bytes.last && fat12 && !complete && (phase_reg == 2'd1);

    assign act0 = complete || odd_tail;
    assign act1 = complete && fat12;
    assign v0   = odd_tail ? {16'b0, bytes.data_byte[3:0], gather_reg[7:0]} : e0;

    assign idx1 = index_inc(index_reg);
    assign idx2 = index_inc(idx1);
    assign win0 = (index_reg >= FIRST_CLUSTER) && (index_reg < cfg.limit);
    assign win1 = (idx1 >= FIRST_CLUSTER) && (idx1 < cfg.limit);

    assign bad0  = act0 && win0 && (v0 == mark);
    assign used0 = act0 && win0 && (v0 != mark) && (v0 != '0);
    assign bad1  = act1 && win1 && (e1 == mark);
    assign used1 = act1 && win1 && (e1 != mark) && (e1 != '0);

    assign rec.n_used = {1'b0, used0} + {1'b0, used1};
    assign rec.n_bad  = {1'b0, bad0} + {1'b0, bad1};
    assign rec.last   = bytes.last;

    always_comb
    begin
        gather_next = gather_reg;
        phase_next  = phase_reg + 2'd1;
        index_next  = index_reg;
        if (bytes.last)
        begin
            gather_next = '0;
            phase_next  = '0;
            index_next  = '0;
        end
        else if (complete)
        begin
            gather_next = '0;
            phase_next  = '0;
            index_next  = act1 ? idx2 : idx1;
        end
        else
        begin
            unique case (phase_reg)
                2'd0:    gather_next = gather_reg | {16'b0, bytes.data_byte};
                2'd1:    gather_next = gather_reg | {8'b0, bytes.data_byte, 8'b0};
                2'd2:    gather_next = gather_reg | {bytes.data_byte, 16'b0};
                default: gather_next = gather_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= '0;
            phase_reg  <= '0;
            index_reg  <= '0;
        end
        else if (take)
        begin
            gather_reg <= gather_next;
            phase_reg  <= phase_next;
            index_reg  <= index_next;
        end
    end

endmodule

FILE: rtl/core/fcuc_queue.sv
`include "fat_cluster_usage_counter_defines.svh"

module fcuc_queue import fcuc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  fcuc_rec_t wr_rec,
    output logic      rd_valid,
    output fcuc_rec_t rd_rec,
    input  logic      rd_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fcuc_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `FCUC_ASSERT_HOLDS(a_count_bound, count_reg <= CNT_FULL)
    `FCUC_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `FCUC_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: rtl/core/fcuc_back.sv
`include "fat_cluster_usage_counter_defines.svh"

module fcuc_back import fcuc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  fcuc_rec_t          rec,
    output logic               rec_ready,
    input  logic [ENTRY_W-1:0] cluster_count,
    fcuc_count_if.source       counts
);

    logic [ENTRY_W-1:0] used_total_reg, bad_total_reg, spent_reg;
    logic [ENTRY_W-1:0] used_next, bad_next, spent_next, free_next;
    logic               out_valid_reg;
    logic [ENTRY_W-1:0] used_out_reg, bad_out_reg, free_out_reg;
    logic               pop;

    // a last record waits only while a previous result is still held
    assign rec_ready = !rec.last || !out_valid_reg || counts.ready;
    assign pop       = rec_valid && rec_ready;

    assign used_next  = used_total_reg + ENTRY_W'(rec.n_used);
    assign bad_next   = bad_total_reg + ENTRY_W'(rec.n_bad);
    assign spent_next = spent_reg + ENTRY_W'(rec.n_used) + ENTRY_W'(rec.n_bad);
    assign free_next  = (cluster_count > spent_next) ? cluster_count - spent_next : '0;

    assign counts.valid      = out_valid_reg;
    assign counts.used_count = used_out_reg;
    assign counts.bad_count  = bad_out_reg;
    assign counts.free_count = free_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_total_reg <= '0;
            bad_total_reg  <= '0;
            spent_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (rec.last)
                begin
                    used_total_reg <= '0;
                    bad_total_reg  <= '0;
                    spent_reg      <= '0;
                end
                else
                begin
                    used_total_reg <= used_next;
                    bad_total_reg  <= bad_next;
                    spent_reg      <= spent_next;
                end
            end
            if (pop && rec.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (counts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && rec.last)
        begin
            used_out_reg <= used_next;
            bad_out_reg  <= bad_next;
            free_out_reg <= free_next;
        end
    end

    `FCUC_ASSERT_HOLDS(a_spent_sum, spent_reg == used_total_reg + bad_total_reg)
    `FCUC_ASSERT_NEXT(a_clear_after_last, pop && rec.last, used_total_reg == '0 && bad_total_reg == '0)
    `FCUC_ASSERT_IMPLIES(a_result_from_last, $rose(out_valid_reg), $past(pop && rec.last))

endmodule
